[design/pusd_pkg.sv]
`timescale 1ns / 1ps

package pusd_pkg;

  localparam logic [31:0] SyncPrefix  = 32'h4242_4344;
  localparam logic [3:0]  HeaderBytes = 4'd9;
  localparam logic [31:0] EosSize     = 32'd13;
  localparam logic [7:0]  EosCode     = 8'h10;
  localparam int unsigned PictureBit  = 3;
  localparam logic [31:0] DistSat     = 32'hFFFF_FFFF;

  // header byte slots, counted down from HeaderBytes
  localparam logic [3:0]  CodeSlot    = 4'd9;
  localparam logic [3:0]  NextLast    = 4'd5;
  localparam logic [3:0]  LastSlot    = 4'd1;

  localparam int unsigned FifoDepth   = 2;
  localparam int unsigned FifoPtrW    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW    = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    LinkFirst    = 2'd0,
    LinkAccepted = 2'd1,
    LinkIgnored  = 2'd2
  } link_e;

  typedef struct packed {
    logic [7:0]  parse_code;
    logic [31:0] next_offset;
    logic [31:0] prev_offset;
    link_e       link_status;
    logic [31:0] unit_distance;
  } hdr_rec_t;

endpackage

[design/parse_unit_sync_deframer_top.sv]
`timescale 1ns / 1ps

// Parse-unit sync deframer: scans a coded byte stream one byte per clock for
// the prefix 0x42424344, captures the 9 header bytes behind it and delivers
// one result per header (parse code, next/previous offsets, link status,
// picture flag, byte distance from the current anchor prefix). The front end
// takes a byte every cycle and makes the link decision as the last header
// byte arrives; results pass through a two-entry queue to a registered output
// stage, and the input only stalls when the queue is full because results are
// not taken.
module parse_unit_sync_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  parse_code_o,
  output logic [31:0] next_offset_o,
  output logic [31:0] prev_offset_o,
  output logic [1:0]  link_status_o,
  output logic        is_picture_o,
  output logic [31:0] unit_distance_o
);

  logic               fifo_full;
  logic               byte_xfer;
  logic               push;
  pusd_pkg::hdr_rec_t push_rec;
  logic               pop;
  logic               fifo_valid;
  pusd_pkg::hdr_rec_t pop_rec;

  assign in_ready_o = !fifo_full;
  assign byte_xfer  = in_valid_i && !fifo_full;

  pusd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_xfer),
    .data_byte_i  (data_byte_i),
    .rec_push_o   (push),
    .rec_o        (push_rec)
  );

  pusd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .valid_o    (fifo_valid),
    .pop_rec_o  (pop_rec)
  );

  pusd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rec_valid_i     (fifo_valid),
    .rec_i           (pop_rec),
    .rec_pop_o       (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .parse_code_o    (parse_code_o),
    .next_offset_o   (next_offset_o),
    .prev_offset_o   (prev_offset_o),
    .link_status_o   (link_status_o),
    .is_picture_o    (is_picture_o),
    .unit_distance_o (unit_distance_o)
  );

endmodule

[design/pusd_front.sv]
`timescale 1ns / 1ps

module pusd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic [7:0]          data_byte_i,
  output logic                rec_push_o,
  output pusd_pkg::hdr_rec_t  rec_o
);

  logic [31:0] win_q, win_d;
  logic [3:0]  hdr_cnt_q, hdr_cnt_d;
  logic [7:0]  code_q, code_d;
  logic [31:0] next_q, next_d;
  logic [31:0] prev_q, prev_d;
  logic        anchor_vld_q, anchor_vld_d;
  logic [31:0] anchor_next_q, anchor_next_d;
  logic [31:0] dist_q, dist_d;

  logic [31:0] win_shift;
  logic [31:0] dist_inc;
  logic [31:0] prev_full;
  logic [31:0] next_sub;
  logic [31:0] dist_rel;
  logic        linked;

  assign win_shift = {win_q[23:0], data_byte_i};
  assign dist_inc  = (dist_q == pusd_pkg::DistSat) ? dist_q : dist_q + 32'd1;
  assign prev_full = {prev_q[23:0], data_byte_i};
  // end of sequence with no next offset carries the fixed unit size
  assign next_sub  = (code_q == pusd_pkg::EosCode && next_q == '0) ?
                     pusd_pkg::EosSize : next_q;
  // dist_inc still includes the header bytes just taken
  assign dist_rel  = (dist_inc == pusd_pkg::DistSat) ? pusd_pkg::DistSat :
                     dist_inc - {28'd0, pusd_pkg::HeaderBytes};
  assign linked    = (prev_full == anchor_next_q) && (prev_full == dist_rel);

  always_comb begin
    win_d         = win_q;
    hdr_cnt_d     = hdr_cnt_q;
    code_d        = code_q;
    next_d        = next_q;
    prev_d        = prev_q;
    anchor_vld_d  = anchor_vld_q;
    anchor_next_d = anchor_next_q;
    dist_d        = dist_q;
    rec_push_o    = 1'b0;
    rec_o.parse_code    = code_q;
    rec_o.next_offset   = next_sub;
    rec_o.prev_offset   = prev_full;
    rec_o.link_status   = pusd_pkg::LinkFirst;
    rec_o.unit_distance = '0;

    if (byte_valid_i) begin
      dist_d = dist_inc;
      if (hdr_cnt_q == '0) begin
        if (win_shift == pusd_pkg::SyncPrefix) begin
          hdr_cnt_d = pusd_pkg::HeaderBytes;
          win_d     = '0;
        end else begin
          win_d = win_shift;
        end
      end else begin
        hdr_cnt_d = hdr_cnt_q - 4'd1;
        if (hdr_cnt_q == pusd_pkg::CodeSlot) begin
          code_d = data_byte_i;
        end else if (hdr_cnt_q >= pusd_pkg::NextLast) begin
          next_d = {next_q[23:0], data_byte_i};
        end else begin
          prev_d = prev_full;
        end

        if (hdr_cnt_q == pusd_pkg::LastSlot) begin
          rec_push_o = 1'b1;
          if (!anchor_vld_q) begin
            anchor_vld_d  = 1'b1;
            anchor_next_d = next_sub;
            dist_d        = {28'd0, pusd_pkg::HeaderBytes};
          end else begin
            rec_o.unit_distance = dist_rel;
            if (linked) begin
              rec_o.link_status = pusd_pkg::LinkAccepted;
              anchor_next_d     = next_sub;
              dist_d            = {28'd0, pusd_pkg::HeaderBytes};
            end else begin
              rec_o.link_status = pusd_pkg::LinkIgnored;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q         <= '0;
      hdr_cnt_q     <= '0;
      code_q        <= '0;
      next_q        <= '0;
      prev_q        <= '0;
      anchor_vld_q  <= 1'b0;
      anchor_next_q <= '0;
      dist_q        <= '0;
    end else begin
      win_q         <= win_d;
      hdr_cnt_q     <= hdr_cnt_d;
      code_q        <= code_d;
      next_q        <= next_d;
      prev_q        <= prev_d;
      anchor_vld_q  <= anchor_vld_d;
      anchor_next_q <= anchor_next_d;
      dist_q        <= dist_d;
    end
  end

endmodule

[design/pusd_fifo.sv]
`timescale 1ns / 1ps

module pusd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pusd_pkg::hdr_rec_t  push_rec_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output pusd_pkg::hdr_rec_t  pop_rec_o
);

  pusd_pkg::hdr_rec_t mem_q [pusd_pkg::FifoDepth];

  logic [pusd_pkg::FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [pusd_pkg::FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [pusd_pkg::FifoCntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o    = (cnt_q == pusd_pkg::FifoCntW'(pusd_pkg::FifoDepth));
  assign valid_o   = (cnt_q != '0);
  assign pop_rec_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == pusd_pkg::FifoPtrW'(pusd_pkg::FifoDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == pusd_pkg::FifoPtrW'(pusd_pkg::FifoDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

[design/pusd_back.sv]
`timescale 1ns / 1ps

module pusd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rec_valid_i,
  input  pusd_pkg::hdr_rec_t  rec_i,
  output logic                rec_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          parse_code_o,
  output logic [31:0]         next_offset_o,
  output logic [31:0]         prev_offset_o,
  output logic [1:0]          link_status_o,
  output logic                is_picture_o,
  output logic [31:0]         unit_distance_o
);

  logic               out_vld_q, out_vld_d;
  pusd_pkg::hdr_rec_t rec_q;
  logic               pic_q;

  assign rec_pop_o = rec_valid_i && (!out_vld_q || out_ready_i);

  always_comb begin
    out_vld_d = out_vld_q;
    if (rec_pop_o) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      rec_q <= rec_i;
      pic_q <= rec_i.parse_code[pusd_pkg::PictureBit];
    end
  end

  assign out_valid_o     = out_vld_q;
  assign parse_code_o    = rec_q.parse_code;
  assign next_offset_o   = rec_q.next_offset;
  assign prev_offset_o   = rec_q.prev_offset;
  assign link_status_o   = rec_q.link_status;
  assign is_picture_o    = pic_q;
  assign unit_distance_o = rec_q.unit_distance;

endmodule
